// ----- rtl/core/tbps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt ball physics step: shared package
// Types, register map and fixed constants used across the block.
// ----------------------------------------------------------------------------
package tbps_pkg;

  // Configuration port geometry: four 32-bit registers at 4-byte spacing.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    REG_GRAVITY_GAIN = 2'd0,
    REG_RADIUS_PX    = 2'd1,
    REG_AREA_WIDTH   = 2'd2,
    REG_AREA_HEIGHT  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] gravity_gain;
    logic [9:0]  radius_px;
    logic [11:0] area_width;
    logic [11:0] area_height;
  } cfg_t;

  localparam logic [15:0] GAIN_RST   = 16'd1000;
  localparam logic [9:0]  RADIUS_RST = 10'd32;
  localparam logic [11:0] WIDTH_RST  = 12'd1366;
  localparam logic [11:0] HEIGHT_RST = 12'd768;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // One second in 100 ns ticks; at or beyond it the frame step saturates.
  localparam logic [62:0] TICKS_PER_SEC = 63'd10000000;
  // dt = floor(ticks * 2^16 / 10^7) = floor(ticks * 2^9 / 78125).
  // Estimate with floor(2^33 / 78125) scaled by 2^-24, then fix by one.
  localparam logic signed [MUL_B_W-1:0] DT_RECIP   = 18'sd109951;
  localparam logic signed [MUL_B_W-1:0] DT_DIVISOR = 18'sd78125;
  localparam logic [15:0]               DT_MAX     = 16'hFFFF;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICKS,
    ST_DT_MUL,
    ST_DT_CHK,
    ST_DT_FIX,
    ST_DV_GAIN,
    ST_DV_TIME,
    ST_SPEED,
    ST_DP_MUL,
    ST_PLACE,
    ST_CLAMP,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/core/tbps_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt ball physics step: channel interfaces
// Frame request channel and ball position result channel.
// ----------------------------------------------------------------------------
interface tbps_in_if;
  logic               valid;
  logic               ready;
  logic               reading_valid;
  logic [62:0]        frame_time;
  logic signed [15:0] tilt_x;
  logic signed [15:0] tilt_y;

  modport source (output valid, output reading_valid, output frame_time,
                  output tilt_x, output tilt_y, input ready);
  modport sink   (input valid, input reading_valid, input frame_time,
                  input tilt_x, input tilt_y, output ready);
endinterface

interface tbps_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] center_x;
  logic [11:0] center_y;

  modport source (output valid, output center_x, output center_y, input ready);
  modport sink   (input valid, input center_x, input center_y, output ready);
endinterface

// ----- rtl/core/tbps_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt ball physics step: configuration registers
// APB-style register file holding gain, radius and play area size.
// ----------------------------------------------------------------------------
module tbps_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tbps_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tbps_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tbps_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output tbps_pkg::cfg_t                  cfg
);
  import tbps_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  // Register writes on the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gravity_gain <= GAIN_RST;
      cfg_r.radius_px    <= RADIUS_RST;
      cfg_r.area_width   <= WIDTH_RST;
      cfg_r.area_height  <= HEIGHT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_GRAVITY_GAIN: cfg_r.gravity_gain <= pwdata[15:0];
        REG_RADIUS_PX:    cfg_r.radius_px    <= pwdata[9:0];
        REG_AREA_WIDTH:   cfg_r.area_width   <= pwdata[11:0];
        REG_AREA_HEIGHT:  cfg_r.area_height  <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  // Read data, zero extended to the bus width.
  always_comb begin
    unique case (idx)
      REG_GRAVITY_GAIN: prdata = {16'd0, cfg_r.gravity_gain};
      REG_RADIUS_PX:    prdata = {22'd0, cfg_r.radius_px};
      REG_AREA_WIDTH:   prdata = {20'd0, cfg_r.area_width};
      REG_AREA_HEIGHT:  prdata = {20'd0, cfg_r.area_height};
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- rtl/core/tbps_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt ball physics step: shared multiplier
// Signed multiplier with a registered product, reused for every product.
// ----------------------------------------------------------------------------
module tbps_mul (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [tbps_pkg::MUL_A_W-1:0]   op_a,
  input  logic signed [tbps_pkg::MUL_B_W-1:0]   op_b,
  output logic signed [tbps_pkg::MUL_P_W-1:0]   prod_r
);
  import tbps_pkg::*;

  logic signed [MUL_P_W-1:0] prod_nxt;

  assign prod_nxt = op_a * op_b;

  // Product register; holds its value while the unit is not used.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

// ----- rtl/core/tilt_ball_physics_step_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt ball physics step unit
// One frame of a rolling ball driven by a two-axis tilt sensor: frame step
// from the timestamp, tilt smoothing, velocity and position integration in
// Q16.16, edge clamping and the pixel center of the ball.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake          Contents
//   in_ch     in         valid/ready        reading_valid, frame_time, tilt
//   out_ch    out        valid/ready        center_x, center_y
//   cfg (APB) in         psel/penable       gain, radius, area width/height
//
// A frame with a reading, once accepted, forms the tick count, then the frame
// step (estimate, back multiply, correction), then per axis the gain and time
// products, speed, position product, position and clamp, and is published.
// The sequencer takes a request only in idle, so such requests never overlap;
// the single shared multiplier serves every product.
// A frame without a reading is accepted in idle and leaves no trace.
// The result sits in an output register, so the next request is accepted
// while it waits; a stalled result holds the sequencer in its last state.
// Reset is synchronous and clears the motion state and the timestamp.
// ----------------------------------------------------------------------------
module tilt_ball_physics_step_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  tbps_in_if.sink                         in_ch,
  tbps_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tbps_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tbps_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tbps_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import tbps_pkg::*;

  // Saturate a wide signed sum to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] res;
    if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
      res = v[31:0];
    end else if (v[34]) begin
      res = 32'sh8000_0000;
    end else begin
      res = 32'sh7FFF_FFFF;
    end
    return res;
  endfunction

  // Whole-pixel center from a Q16.16 position, clipped to 0..4095.
  function automatic logic [11:0] pixel_of(input logic signed [31:0] p);
    logic [11:0] res;
    if (p[31]) begin
      res = 12'd0;
    end else if (p[30:28] != 3'd0) begin
      res = 12'hFFF;
    end else begin
      res = p[27:16];
    end
    return res;
  endfunction

  cfg_t cfg;

  tbps_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  state_t state_r, state_nxt;

  // Motion state.
  logic [62:0]        last_time_r;
  logic signed [15:0] smooth_ax_r, smooth_ay_r;
  logic signed [31:0] speed_x_r, speed_y_r, place_x_r, place_y_r;
  logic               axis_r;
  logic               out_valid_r;

  // Per-request working registers.
  logic [62:0]        now_r;
  logic signed [15:0] tilt_x_r, tilt_y_r;
  logic [62:0]        ticks_r;
  logic [15:0]        dt_r;
  logic [11:0]        center_x_r, center_y_r;

  // Shared multiplier.
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [MUL_P_W-1:0] prod_r;

  tbps_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  logic in_accept, out_free;

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign in_accept       = in_ch.valid && in_ch.ready;
  assign out_free        = !out_valid_r || out_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.center_x = center_x_r;
  assign out_ch.center_y = center_y_r;

  // Current axis selection.
  logic signed [15:0] smooth_cur;
  logic signed [31:0] speed_cur, place_cur;
  logic [11:0]        size_cur;

  assign smooth_cur = axis_r ? smooth_ay_r : smooth_ax_r;
  assign speed_cur  = axis_r ? speed_y_r   : speed_x_r;
  assign place_cur  = axis_r ? place_y_r   : place_x_r;
  assign size_cur   = axis_r ? cfg.area_height : cfg.area_width;

  // Tilt smoothing: Y is negated, then each axis averages with its history.
  logic signed [15:0] ay_in;
  logic signed [16:0] sum_x, sum_y;

  assign ay_in = (tilt_y_r == 16'sh8000) ? 16'sh7FFF : -tilt_y_r;
  assign sum_x = {smooth_ax_r[15], smooth_ax_r} + {tilt_x_r[15], tilt_x_r};
  assign sum_y = {smooth_ay_r[15], smooth_ay_r} + {ay_in[15], ay_in};

  // Frame step correction: remainder of ticks * 2^9 against estimate * 78125.
  logic        dt_sat;
  logic [33:0] dt_rem;
  logic [15:0] dt_fixed;

  assign dt_sat   = (ticks_r >= TICKS_PER_SEC);
  assign dt_rem   = {1'b0, ticks_r[23:0], 9'd0} - {1'b0, prod_r[32:0]};
  assign dt_fixed = dt_sat ? DT_MAX :
                    (dt_rem >= {16'd0, DT_DIVISOR}) ? dt_r + 16'd1 : dt_r;

  // Velocity update: dv = floor(gain * smooth * dt / 2^14).
  logic signed [34:0] speed_sum;
  assign speed_sum = {{3{speed_cur[31]}}, speed_cur} + {prod_r[47], prod_r[47:14]};

  // Position update: dp = floor(speed * dt / 2^16).
  logic signed [34:0] place_sum;
  assign place_sum = {{3{place_cur[31]}}, place_cur} + {{3{prod_r[47]}}, prod_r[47:16]};

  // Edge limits in Q16.16 and the clamp decision.
  logic signed [12:0] hi_px;
  logic signed [31:0] lo_lim, hi_lim, place_clamped;
  logic               hit_lo, hit_hi;

  assign hi_px   = $signed({1'b0, size_cur}) - $signed({3'b000, cfg.radius_px});
  assign lo_lim  = {6'd0, cfg.radius_px, 16'd0};
  assign hi_lim  = {{3{hi_px[12]}}, hi_px, 16'd0};
  assign hit_lo  = (place_cur < lo_lim);
  assign hit_hi  = hit_lo ? (lo_lim > hi_lim) : (place_cur > hi_lim);
  assign place_clamped = hit_hi ? hi_lim : (hit_lo ? lo_lim : place_cur);

  // Multiplier operand selection per step.
  always_comb begin
    mul_en = 1'b0;
    op_a   = '0;
    op_b   = '0;
    case (state_r)
      ST_DT_MUL: begin
        mul_en = 1'b1;
        op_a   = {10'd0, ticks_r[23:0]};
        op_b   = DT_RECIP;
      end
      ST_DT_CHK: begin
        mul_en = 1'b1;
        op_a   = {18'd0, prod_r[39:24]};
        op_b   = DT_DIVISOR;
      end
      ST_DV_GAIN: begin
        mul_en = 1'b1;
        op_a   = {18'd0, cfg.gravity_gain};
        op_b   = {{2{smooth_cur[15]}}, smooth_cur};
      end
      ST_DV_TIME: begin
        mul_en = 1'b1;
        op_a   = prod_r[MUL_A_W-1:0];
        op_b   = {2'b00, dt_r};
      end
      ST_DP_MUL: begin
        mul_en = 1'b1;
        op_a   = {{2{speed_cur[31]}}, speed_cur};
        op_b   = {2'b00, dt_r};
      end
      default: ;
    endcase
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_accept && in_ch.reading_valid) state_nxt = ST_TICKS;
      ST_TICKS:   state_nxt = ST_DT_MUL;
      ST_DT_MUL:  state_nxt = ST_DT_CHK;
      ST_DT_CHK:  state_nxt = ST_DT_FIX;
      ST_DT_FIX:  state_nxt = ST_DV_GAIN;
      ST_DV_GAIN: state_nxt = ST_DV_TIME;
      ST_DV_TIME: state_nxt = ST_SPEED;
      ST_SPEED:   state_nxt = ST_DP_MUL;
      ST_DP_MUL:  state_nxt = ST_PLACE;
      ST_PLACE:   state_nxt = ST_CLAMP;
      ST_CLAMP:   state_nxt = axis_r ? ST_DONE : ST_DV_GAIN;
      ST_DONE:    if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Motion state and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      smooth_ax_r <= '0;
      smooth_ay_r <= '0;
      speed_x_r   <= '0;
      speed_y_r   <= '0;
      place_x_r   <= '0;
      place_y_r   <= '0;
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // The result register fills when a result is published and empties on acceptance.
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_TICKS: begin
          last_time_r <= now_r;
          smooth_ax_r <= sum_x[16:1];
          smooth_ay_r <= sum_y[16:1];
          axis_r      <= 1'b0;
        end
        ST_SPEED: begin
          if (axis_r) speed_y_r <= sat32(speed_sum);
          else        speed_x_r <= sat32(speed_sum);
        end
        ST_PLACE: begin
          if (axis_r) place_y_r <= sat32(place_sum);
          else        place_x_r <= sat32(place_sum);
        end
        ST_CLAMP: begin
          if (axis_r) begin
            place_y_r <= place_clamped;
            if (hit_lo || hit_hi) speed_y_r <= '0;
          end else begin
            place_x_r <= place_clamped;
            if (hit_lo || hit_hi) speed_x_r <= '0;
          end
          axis_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Working registers for the request in flight and the result payload.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          now_r    <= in_ch.frame_time;
          tilt_x_r <= in_ch.tilt_x;
          tilt_y_r <= in_ch.tilt_y;
        end
      end
      ST_TICKS:  ticks_r <= now_r - last_time_r;
      ST_DT_CHK: dt_r    <= prod_r[39:24];
      ST_DT_FIX: dt_r    <= dt_fixed;
      ST_DONE: begin
        if (out_free) begin
          center_x_r <= pixel_of(place_x_r);
          center_y_r <= pixel_of(place_y_r);
        end
      end
      default: ;
    endcase
  end

endmodule
